// ----- rtl/core/bb3_pkg.sv -----
// Shared types and constants for the 3x3 box blur stream block.
package bb3_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 12;
    localparam int MULT_W      = 12;
    localparam int DIV9_MULT   = 3641;
    localparam int DIV9_SHIFT  = 15;
    localparam int ROWS_REG_W  = 13;
    localparam int COLS_REG_W  = 11;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register select taken from paddr bit 2.
    localparam logic REG_FRAME_ROWS = 1'b0;
    localparam logic REG_FRAME_COLS = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [2*PIX_W-1:0] t_ls_word;
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic has_res;
        logic row_lo;
        logic row_hi;
        logic col_lo;
        logic col_hi;
        logic last;
    } t_pos;

endpackage

// ----- rtl/core/bb3_cfg.sv -----
// Configuration registers with APB-style access and frame size clamping.
module bb3_cfg #(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 1024,
    localparam int RCW = $clog2(MAX_ROWS + 2),
    localparam int CEW = $clog2(MAX_COLS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bb3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bb3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bb3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic                               o_cfg_wr,
    output logic [RCW-1:0]                     o_rows,
    output logic [CEW-1:0]                     o_cols
);

    logic [bb3_pkg::ROWS_REG_W-1:0] r_rows_raw;
    logic [bb3_pkg::COLS_REG_W-1:0] r_cols_raw;
    logic [RCW-1:0]                 r_rows_eff;
    logic [CEW-1:0]                 r_cols_eff;
    logic [RCW-1:0]                 n_rows_eff;
    logic [CEW-1:0]                 n_cols_eff;
    logic                           wr;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;
    assign o_cfg_wr = wr;
    assign o_rows   = r_rows_eff;
    assign o_cols   = r_cols_eff;

    always_comb begin
        int rv;
        int cv;
        rv = int'(pwdata[bb3_pkg::ROWS_REG_W-1:0]);
        cv = int'(pwdata[bb3_pkg::COLS_REG_W-1:0]);
        if (rv < 1) begin
            rv = 1;
        end
        if (rv > MAX_ROWS) begin
            rv = MAX_ROWS;
        end
        if (cv < 1) begin
            cv = 1;
        end
        if (cv > MAX_COLS) begin
            cv = MAX_COLS;
        end
        n_rows_eff = RCW'(rv);
        n_cols_eff = CEW'(cv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_raw <= bb3_pkg::ROWS_REG_W'(1);
            r_cols_raw <= bb3_pkg::COLS_REG_W'(1);
            r_rows_eff <= RCW'(1);
            r_cols_eff <= CEW'(1);
        end else if (wr) begin
            if (paddr[2] == bb3_pkg::REG_FRAME_COLS) begin
                r_cols_raw <= pwdata[bb3_pkg::COLS_REG_W-1:0];
                r_cols_eff <= n_cols_eff;
            end else begin
                r_rows_raw <= pwdata[bb3_pkg::ROWS_REG_W-1:0];
                r_rows_eff <= n_rows_eff;
            end
        end
    end

    always_comb begin
        if (paddr[2] == bb3_pkg::REG_FRAME_COLS) begin
            prdata = bb3_pkg::APB_DATA_W'(r_cols_raw);
        end else begin
            prdata = bb3_pkg::APB_DATA_W'(r_rows_raw);
        end
    end

endmodule

// ----- rtl/core/bb3_ctrl.sv -----
// Input position counters, flush handling and result position decode.
module bb3_ctrl #(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 1024,
    localparam int RCW = $clog2(MAX_ROWS + 2),
    localparam int CEW = $clog2(MAX_COLS + 1),
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic [RCW-1:0]      i_rows,
    input  logic [CEW-1:0]      i_cols,
    input  logic                i_valid,
    input  bb3_pkg::t_pix       i_pix,
    input  logic                i_flush,
    input  logic                i_slot_free,
    output logic                o_ready,
    output logic                o_step,
    output bb3_pkg::t_pix       o_x,
    output logic [CW-1:0]       o_ci,
    output bb3_pkg::t_pos       o_pos
);

    logic [RCW-1:0] r_ri;
    logic [CW-1:0]  r_ci;
    logic           r_extra;
    logic           active;
    logic           wrap;
    logic           c1;
    logic           c2;

    assign active  = r_ri < i_rows;
    assign o_ready = i_slot_free && !r_extra;
    assign o_step  = (i_valid && o_ready && (!active || !i_flush)) || (r_extra && i_slot_free);
    assign o_x     = (r_extra || !active) ? '0 : i_pix;
    assign o_ci    = r_ci;
    assign wrap    = (CEW'(r_ci) + CEW'(1)) >= i_cols;

    assign c1 = (r_ci != '0) && (r_ri != '0);
    assign c2 = (r_ci == '0) && (r_ri > RCW'(1));

    always_comb begin
        o_pos.has_res = c1 || c2;
        o_pos.row_lo  = c1 ? (r_ri > RCW'(1)) : (r_ri > RCW'(2));
        o_pos.row_hi  = c1 ? (r_ri < i_rows) : (r_ri <= i_rows);
        o_pos.col_lo  = c1 ? (r_ci > CW'(1)) : (i_cols != CEW'(1));
        o_pos.col_hi  = c1;
        o_pos.last    = c2 && (r_ri == i_rows + RCW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ri    <= '0;
            r_ci    <= '0;
            r_extra <= 1'b0;
        end else if (o_step) begin
            if (o_pos.last) begin
                r_ri <= '0;
                r_ci <= '0;
            end else if (wrap) begin
                r_ri <= r_ri + RCW'(1);
                r_ci <= '0;
            end else begin
                r_ci <= r_ci + CW'(1);
            end
            // A single-row frame takes one silent drain step right after its last pixel.
            r_extra <= !r_extra && active && (i_rows == RCW'(1)) && wrap;
        end
    end

endmodule

// ----- rtl/core/bb3_line_store.sv -----
// Two line stores packed in one memory word, with a registered read and write bypass.
module bb3_line_store #(
    parameter int MAX_COLS = 1024,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [CW-1:0]       i_rd_addr,
    input  logic                i_wr_en,
    input  logic [CW-1:0]       i_wr_addr,
    input  bb3_pkg::t_ls_word   i_wr_data,
    output bb3_pkg::t_ls_word   o_rd_data
);

    bb3_pkg::t_ls_word mem [MAX_COLS];
    bb3_pkg::t_ls_word r_rd;

    assign o_rd_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= mem[i_rd_addr];
            end
        end
    end

endmodule

// ----- rtl/core/bb3_window.sv -----
// Tap stage and 3x3 window registers with border masking.
module bb3_window #(
    parameter int MAX_COLS = 1024,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_step,
    input  bb3_pkg::t_pix       i_x,
    input  logic [CW-1:0]       i_ci,
    input  bb3_pkg::t_pos       i_pos,
    input  bb3_pkg::t_ls_word   i_rd_data,
    input  logic                i_next_ready,
    output logic                o_slot_free,
    output logic                o_wr_en,
    output logic [CW-1:0]       o_wr_addr,
    output bb3_pkg::t_ls_word   o_wr_data,
    output logic                o_valid,
    output bb3_pkg::t_win       o_win,
    output logic                o_last
);

    logic               r_a_valid;
    bb3_pkg::t_pix      r_a_x;
    logic [CW-1:0]      r_a_ci;
    bb3_pkg::t_pos      r_a_pos;
    bb3_pkg::t_win      r_win;
    bb3_pkg::t_win      shifted;
    logic [2:0]         tap_lo;
    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic               adv;

    assign adv         = r_a_valid && (!r_a_pos.has_res || i_next_ready);
    assign o_slot_free = !r_a_valid || adv;
    assign o_wr_en     = adv;
    assign o_wr_addr   = r_a_ci;
    assign o_wr_data   = {i_rd_data[bb3_pkg::PIX_W-1:0], r_a_x};
    assign o_valid     = adv && r_a_pos.has_res;
    assign o_last      = r_a_pos.last;
    assign row_ok      = {r_a_pos.row_hi, 1'b1, r_a_pos.row_lo};
    assign col_ok      = {r_a_pos.col_hi, 1'b1, r_a_pos.col_lo};
    assign tap_lo      = 3'b111;

    always_comb begin
        for (int tr = 0; tr < 3; tr++) begin
            shifted[tr][0] = r_win[tr][1];
            shifted[tr][1] = r_win[tr][2];
        end
        shifted[0][2] = i_rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
        shifted[1][2] = i_rd_data[bb3_pkg::PIX_W-1:0];
        shifted[2][2] = r_a_x;
        for (int tr = 0; tr < 3; tr++) begin
            for (int tc = 0; tc < 3; tc++) begin
                if (row_ok[tr] && col_ok[tc] && tap_lo[tc]) begin
                    o_win[tr][tc] = shifted[tr][tc];
                end else begin
                    o_win[tr][tc] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_step) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_a_x   <= i_x;
            r_a_ci  <= i_ci;
            r_a_pos <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_win <= '0;
        end else if (adv) begin
            // The frame restarts after its final result, so the window starts empty.
            r_win <= r_a_pos.last ? '0 : shifted;
        end
    end

endmodule

// ----- rtl/core/bb3_sum_div.sv -----
// Window sum, divide by nine and the output register.
module bb3_sum_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bb3_pkg::t_win       i_win,
    input  logic                i_last,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_out_ready,
    output bb3_pkg::t_pix       o_value,
    output logic                o_last
);

    localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::MULT_W;

    logic                       r_b_valid;
    bb3_pkg::t_win              r_b_win;
    logic                       r_b_last;
    logic                       r_c_valid;
    logic [bb3_pkg::SUM_W-1:0]  r_c_sum;
    logic                       r_c_last;
    logic                       r_o_valid;
    bb3_pkg::t_pix              r_o_value;
    logic                       r_o_last;
    logic [bb3_pkg::SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0]          prod;
    logic                       rdy_o;
    logic                       rdy_c;
    logic                       rdy_b;

    assign rdy_o   = !r_o_valid || i_out_ready;
    assign rdy_c   = !r_c_valid || rdy_o;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign o_ready = rdy_b;
    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;

    always_comb begin
        n_sum = '0;
        for (int tr = 0; tr < 3; tr++) begin
            for (int tc = 0; tc < 3; tc++) begin
                n_sum = n_sum + bb3_pkg::SUM_W'(r_b_win[tr][tc]);
            end
        end
    end

    // Exact for sums below 2**15, well above the largest window sum.
    assign prod = PROD_W'(r_c_sum) * PROD_W'(bb3_pkg::DIV9_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rdy_b) begin
                r_b_valid <= i_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_o) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_win  <= i_win;
            r_b_last <= i_last;
        end
        if (rdy_c) begin
            r_c_sum  <= n_sum;
            r_c_last <= r_b_last;
        end
        if (rdy_o) begin
            r_o_value <= prod[bb3_pkg::DIV9_SHIFT +: bb3_pkg::PIX_W];
            r_o_last  <= r_c_last;
        end
    end

endmodule

// ----- rtl/core/box_blur_3x3_stream.sv -----
// Top level of the 3x3 box blur stream block.
// The block takes one pixel transfer per clock and gives one result transfer per clock
// when not stalled. A result passes the tap, window, sum and output registers after the
// pixel or flush item that completes its 3x3 neighborhood, and results lag the pixel
// stream by one row plus one column, so the host sends one flush item per pending
// result after the frame's last pixel. The two line stores share one memory that is
// read and written at most once per cycle; after the last pixel of a single-row frame
// the input pauses while the block takes a drain step. Writing either size register
// restarts the frame; the user does so only while the block is idle (unenforced).
module box_blur_3x3_stream #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] pixel_value
    input  logic                               i_s_tuser,   // [0] is_flush
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // [7:0] smoothed_value
    output logic                               o_m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bb3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bb3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bb3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int RCW = $clog2(MAX_ROWS + 2);
    localparam int CEW = $clog2(MAX_COLS + 1);
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                cfg_wr;
    logic [RCW-1:0]      rows;
    logic [CEW-1:0]      cols;
    logic                slot_free;
    logic                step;
    bb3_pkg::t_pix       step_x;
    logic [CW-1:0]       step_ci;
    bb3_pkg::t_pos       step_pos;
    bb3_pkg::t_ls_word   rd_data;
    logic                wr_en;
    logic [CW-1:0]       wr_addr;
    bb3_pkg::t_ls_word   wr_data;
    logic                win_valid;
    bb3_pkg::t_win       win;
    logic                win_last;
    logic                sum_ready;

    bb3_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg_wr (cfg_wr),
        .o_rows   (rows),
        .o_cols   (cols)
    );

    bb3_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_rows      (rows),
        .i_cols      (cols),
        .i_valid     (i_s_tvalid),
        .i_pix       (i_s_tdata),
        .i_flush     (i_s_tuser),
        .i_slot_free (slot_free),
        .o_ready     (o_s_tready),
        .o_step      (step),
        .o_x         (step_x),
        .o_ci        (step_ci),
        .o_pos       (step_pos)
    );

    bb3_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (step),
        .i_rd_addr (step_ci),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    bb3_window #(
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_wr),
        .i_step       (step),
        .i_x          (step_x),
        .i_ci         (step_ci),
        .i_pos        (step_pos),
        .i_rd_data    (rd_data),
        .i_next_ready (sum_ready),
        .o_slot_free  (slot_free),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_valid      (win_valid),
        .o_win        (win),
        .o_last       (win_last)
    );

    bb3_sum_div u_sum_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (win_valid),
        .i_win       (win),
        .i_last      (win_last),
        .o_ready     (sum_ready),
        .o_valid     (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_value     (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule

// ----- rtl/core/bb3_port_checker.sv -----
// Port-level assertions for the box blur stream block and their bind.
module bb3_port_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [7:0]                         o_m_tdata,
    input logic                               o_m_tlast,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic                               pready,
    input logic [bb3_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [bb3_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [bb3_pkg::APB_DATA_W-1:0]     prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("Stalled result transfer changed.");

    a_rows_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2] == bb3_pkg::REG_FRAME_ROWS) |=>
            (paddr[2] != bb3_pkg::REG_FRAME_ROWS ||
             prdata == bb3_pkg::APB_DATA_W'($past(pwdata[bb3_pkg::ROWS_REG_W-1:0]))))
        else $error("Row count register does not read back the written value.");

    a_cols_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2] == bb3_pkg::REG_FRAME_COLS) |=>
            (paddr[2] != bb3_pkg::REG_FRAME_COLS ||
             prdata == bb3_pkg::APB_DATA_W'($past(pwdata[bb3_pkg::COLS_REG_W-1:0]))))
        else $error("Column count register does not read back the written value.");

endmodule

bind box_blur_3x3_stream bb3_port_checker u_port_checker (.*);

// ----- sim/box_blur_3x3_stream_tb.sv -----
// Self-checking testbench for the 3x3 box blur stream block with a built-in blur predictor.
module box_blur_3x3_stream_tb;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 4096;
    localparam int ITEM_TARGET   = 680;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 500;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {CFG_BOTH, CFG_ROWS_ONLY, CFG_COLS_ONLY} t_cfg_sel;

    typedef struct packed {
        logic [bb3_pkg::PIX_W-1:0] value;
        logic                      last;
    } t_blur_out;

    class blur_checker;
        bit [bb3_pkg::ROWS_REG_W-1:0] rows_reg = bb3_pkg::ROWS_REG_W'(1);
        bit [bb3_pkg::COLS_REG_W-1:0] cols_reg = bb3_pkg::COLS_REG_W'(1);
        bit [bb3_pkg::PIX_W-1:0]      upper_line [MAX_COLS];
        bit [bb3_pkg::PIX_W-1:0]      middle_line [MAX_COLS];
        bit [bb3_pkg::PIX_W-1:0]      win [9];
        int unsigned                  in_row;
        int unsigned                  in_col;
        t_blur_out                    expected_smoothed [$];
        int                           errors;

        function int rows_eff();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return int'(rows_reg);
        endfunction

        function int cols_eff();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return int'(cols_reg);
        endfunction

        function void restart();
            foreach (win[k]) win[k] = '0;
            in_row = 0;
            in_col = 0;
        endfunction

        function void set_size(input logic sel, input int unsigned value);
            if (sel == bb3_pkg::REG_FRAME_ROWS) begin
                rows_reg = bb3_pkg::ROWS_REG_W'(value);
            end else begin
                cols_reg = bb3_pkg::COLS_REG_W'(value);
            end
            restart();
        endfunction

        // True once every pixel of the frame has been taken and lagging results remain.
        function bit in_drain();
            return in_row >= rows_eff();
        endfunction

        function bit shift_in(input bit [bb3_pkg::PIX_W-1:0] x, output t_blur_out res);
            int rows, cols, ri, ci, cr, cc, ir, ic, r, c;
            int unsigned total;
            bit [bb3_pkg::PIX_W-1:0] tap [3];
            rows = rows_eff();
            cols = cols_eff();
            ri = in_row;
            ci = in_col;
            res = '0;
            tap[0] = upper_line[ci];
            tap[1] = middle_line[ci];
            tap[2] = x;
            upper_line[ci] = tap[1];
            middle_line[ci] = x;
            for (r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
                win[r*3+2] = tap[r];
            end
            if (ci + 1 >= cols) begin
                in_col = 0;
                in_row = ri + 1;
            end else begin
                in_col = ci + 1;
            end
            if (ci >= 1 && ri >= 1) begin
                cr = ri - 1;
                cc = ci - 1;
            end else if (ci == 0 && ri >= 2) begin
                cr = ri - 2;
                cc = cols - 1;
            end else begin
                return 1'b0;
            end
            total = 0;
            for (r = 0; r < 3; r++) begin
                ir = cr - 1 + r;
                if (ir >= 0 && ir < rows) begin
                    for (c = 0; c < 3; c++) begin
                        ic = cc - 1 + c;
                        if (ic >= 0 && ic < cols) total += win[r*3+c];
                    end
                end
            end
            res.value = bb3_pkg::PIX_W'(total / 9);
            res.last = (cr == rows - 1 && cc == cols - 1);
            if (res.last) restart();
            return 1'b1;
        endfunction

        // Returns 1 unless the item was dropped by the block.
        function bit take_pixel(input logic [bb3_pkg::PIX_W-1:0] pix, input logic flush);
            t_blur_out res;
            bit got;
            if (in_row < rows_eff()) begin
                if (flush) return 1'b0;
                got = shift_in(pix, res);
                // A single-row frame takes a silent drain step right after its last pixel.
                if (!got && rows_eff() == 1 && in_row == 1 && in_col == 0) got = shift_in('0, res);
            end else begin
                got = shift_in('0, res);
            end
            if (got) expected_smoothed = {expected_smoothed, res};
            return 1'b1;
        endfunction

        function void check_smoothed(input logic [bb3_pkg::PIX_W-1:0] value, input logic last);
            t_blur_out want;
            if (expected_smoothed.size() == 0) begin
                $error("unexpected result: smoothed_value %0d, frame_last %0b", value, last);
                errors++;
                return;
            end
            want = expected_smoothed.pop_front();
            if (value !== want.value) begin
                $error("smoothed_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $error("frame_last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [7:0]                     i_s_tdata = '0;   // [7:0] pixel_value
    logic                           i_s_tuser = 1'b0; // [0] is_flush
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [7:0]                     o_m_tdata;        // [7:0] smoothed_value
    logic                           o_m_tlast;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [bb3_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bb3_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bb3_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    blur_checker sb = new;
    t_idle_mode  idle_mode = IDLE_NONE;
    int          rx_hold = 0;
    int          fed_items = 0;
    int          quiet_cycles = 0;

    box_blur_3x3_stream #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 64;
            IDLE_BOTH:   return 6;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 64;
            IDLE_BOTH:     return 6;
            default:       return 0;
        endcase
    endfunction

    task automatic send_item(input logic [7:0] pix, input logic flush);
        if ($urandom_range(0, 99) < sender_idle_pct()) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= 8'($urandom);
            i_s_tuser <= 1'($urandom);
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct());
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pix;
        i_s_tuser <= flush;
        do @(posedge i_clk); while (!o_s_tready);
        if (sb.take_pixel(pix, flush)) fed_items++;
    endtask

    // Stops sending and waits until every expected result has left the block.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.expected_smoothed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_size(sel, value);
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned rows, input int unsigned cols,
                             input t_cfg_sel which);
        settle();
        if (which != CFG_COLS_ONLY) write_reg(bb3_pkg::REG_FRAME_ROWS, rows);
        if (which != CFG_ROWS_ONLY) write_reg(bb3_pkg::REG_FRAME_COLS, cols);
    endtask

    // Sends one frame of random pixels and the flush items that drain it.
    // A cut index stops the frame early; noise adds stray flushes and pixels in the drain.
    task automatic send_frame(input bit noisy, input int cut);
        int total;
        int k;
        total = sb.rows_eff() * sb.cols_eff();
        for (k = 0; k < total && k != cut; k++) begin
            if (noisy && $urandom_range(0, 24) == 0) send_item(8'($urandom), 1'b1);
            send_item(8'($urandom), 1'b0);
        end
        if (k == cut) return;
        while (sb.in_drain())
            send_item(8'($urandom), (noisy && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1);
        if (noisy && $urandom_range(0, 4) == 0) send_item(8'($urandom), 1'b1);
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) sb.check_smoothed(o_m_tdata, o_m_tlast);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned rows;
        int unsigned cols;
        int cut;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size is one pixel: a single flush drains it, a second flush is dropped.
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hA5, 1'b1);

        // A flush before the first pixel is dropped; pixels after frame end act as flushes.
        configure(3, 3, CFG_BOTH);
        send_item(8'h5A, 1'b1);
        for (int k = 0; k < 9; k++) send_item((k == 4) ? 8'h00 : 8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        while (sb.in_drain()) send_item(8'h00, 1'b1);
        send_item(8'h33, 1'b1);

        // Single-row frame.
        configure(1, 4, CFG_BOTH);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        while (sb.in_drain()) send_item(8'h00, 1'b1);

        // Long receiver hold-off while the sender keeps offering a whole frame.
        configure(6, 5, CFG_BOTH);
        rx_hold = HOLD_CYCLES;
        send_frame(1'b0, -1);
        settle();

        while (fed_items < ITEM_TARGET) begin
            idle_mode = t_idle_mode'($urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0) begin
                rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                cols = ($urandom_range(0, 9) == 0) ? 0 :
                       ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
                configure(rows, cols, t_cfg_sel'($urandom_range(0, 2)));
            end
            cut = ($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, sb.rows_eff() * sb.cols_eff() - 1) : -1;
            send_frame(1'b1, cut);
        end

        // Largest row count, raw values above the limits and zero sizes.
        idle_mode = t_idle_mode'($urandom_range(0, 3));
        configure(MAX_ROWS, 1, CFG_BOTH);
        send_frame(1'b0, 24);
        idle_mode = IDLE_NONE;
        configure(8191, 2047, CFG_BOTH);
        send_frame(1'b0, 24);
        configure(0, 0, CFG_BOTH);
        send_frame(1'b0, -1);

        settle();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
